/* src/pss_pkg.sv */
package pss_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHININESS = 3'd4;

	// iterative square root / divide unit
	localparam int IU_N_W        = 56;	// radicand or numerator
	localparam int IU_D_W        = 28;	// divisor
	localparam int IU_R_W        = 31;	// partial remainder
	localparam int IU_RES_W      = 28;	// root or quotient
	localparam int IU_SQRT_STEPS = 28;
	localparam int DIV_N_W       = 44;	// numerator bits used by a divide
	localparam int DIV_Q_W       = 17;	// quotient bits, also divide steps
	localparam int IU_CNT_W      = 5;

	typedef enum logic [0:0] {
		IU_SQRT = 1'b0,
		IU_DIV  = 1'b1
	} iu_op_t;

	typedef struct packed {
		logic               start;
		iu_op_t             op;
		logic [IU_N_W-1:0]  num;
		logic [IU_D_W-1:0]  den;
	} iu_req_t;

	typedef struct packed {
		logic                done;
		logic [IU_RES_W-1:0] result;
	} iu_rsp_t;

endpackage

/* src/pss_if.sv */
interface pss_in_if #(
	parameter int COORD_BITS = 11
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic signed [15:0]           light_pos_x;
	logic signed [15:0]           light_pos_y;
	logic signed [15:0]           light_pos_z;
	logic [15:0]                  light_red;
	logic [15:0]                  light_green;
	logic [15:0]                  light_blue;
	logic                         light_is_directional;
	logic                         last_light;

	modport source (
		output valid, pixel_x, pixel_y, light_pos_x, light_pos_y, light_pos_z,
		output light_red, light_green, light_blue, light_is_directional, last_light,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, light_pos_x, light_pos_y, light_pos_z,
		input  light_red, light_green, light_blue, light_is_directional, last_light,
		output ready
	);
endinterface

interface pss_out_if ();
	logic        valid;
	logic        ready;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic        outside_sphere;

	modport source (output valid, red, green, blue, outside_sphere, input ready);
	modport sink (input valid, red, green, blue, outside_sphere, output ready);
endinterface

interface pss_cfg_if import pss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/pss_iter_unit.sv */
module pss_iter_unit import pss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  iu_req_t req,
	output iu_rsp_t rsp
);

	logic                busy_q;
	iu_op_t              op_q;
	logic [IU_CNT_W-1:0] cnt_q;
	logic [IU_R_W-1:0]   rem_q;
	logic [IU_N_W-1:0]   work_q;
	logic [IU_RES_W-1:0] res_q;
	logic [IU_D_W-1:0]   den_q;

	logic [IU_R_W-1:0]   rem_sh;
	logic [IU_R_W-1:0]   sub_b;
	logic [IU_R_W:0]     diff;
	logic                ge;

	// one root digit or one quotient bit per cycle through a shared subtractor
	always_comb begin
		if (op_q == IU_SQRT) begin
			rem_sh = {rem_q[IU_R_W-3:0], work_q[IU_N_W-1 -: 2]};
			sub_b  = IU_R_W'({res_q, 2'b01});
		end else begin
			rem_sh = {rem_q[IU_R_W-2:0], work_q[IU_N_W-1]};
			sub_b  = IU_R_W'(den_q);
		end
		diff = {1'b0, rem_sh} - {1'b0, sub_b};
		ge   = ~diff[IU_R_W];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= (req.op == IU_SQRT) ? IU_CNT_W'(IU_SQRT_STEPS) : IU_CNT_W'(DIV_Q_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			den_q <= req.den;
			res_q <= '0;
			if (req.op == IU_SQRT) begin
				rem_q  <= '0;
				work_q <= req.num;
			end else begin
				rem_q  <= IU_R_W'(req.num[DIV_N_W-1:DIV_Q_W]);
				work_q <= {req.num[DIV_Q_W-1:0], (IU_N_W-DIV_Q_W)'(0)};
			end
		end else if (busy_q && cnt_q != '0) begin
			rem_q  <= ge ? diff[IU_R_W-1:0] : rem_sh;
			res_q  <= {res_q[IU_RES_W-2:0], ge};
			work_q <= (op_q == IU_SQRT) ? (work_q << 2) : (work_q << 1);
		end
	end

	assign rsp.done   = busy_q && (cnt_q == '0);
	assign rsp.result = res_q;

endmodule

/* src/phong_sphere_pixel_shader.sv */
// channel     dir   beat content
// pixel_in    in    one light for the current pixel (position, colour, kind, last flag)
// shade_out   out   summed shade of a pixel, emitted on its last light
// cfg         in    register write: index and data, always ready
//
// for a pixel inside the sphere a light runs two square roots of 28 steps and six
// divides of 17 steps, one bit a cycle in the shared iterative unit; the remaining
// products share one multiplier, and the exponent takes a check and a squaring step
// per bit of shininess and a multiply step more per set bit. a zero-length light
// vector adds only the ambient term, and a pixel outside the sphere skips all shading.
// reset clears the sums and sets the registers to their defaults; pixel_in is ready
// only when idle, and a full output register stalls the last step of a pixel.
module phong_sphere_pixel_shader import pss_pkg::*; #(
	parameter int COORD_BITS    = 11,
	parameter int SHININESS_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	pss_in_if.sink      pixel_in,
	pss_out_if.source   shade_out,
	pss_cfg_if.sink     cfg
);

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 28;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int Z_W     = 23;
	localparam int V_W     = 27;
	localparam int NL_W    = 17;
	localparam int DOT_W   = 18;
	localparam int TERM_W  = 18;
	localparam int SUM_W   = 24;
	localparam logic [15:0] ONE_Q15 = 16'h8000;

	typedef enum logic [24:0] {
		ST_IDLE = 25'd1 << 0,
		ST_RR   = 25'd1 << 1,
		ST_XX   = 25'd1 << 2,
		ST_YY   = 25'd1 << 3,
		ST_CHK  = 25'd1 << 4,
		ST_SQZ  = 25'd1 << 5,
		ST_NDIV = 25'd1 << 6,
		ST_VMUL = 25'd1 << 7,
		ST_LMUL = 25'd1 << 8,
		ST_AMB  = 25'd1 << 9,
		ST_SQL  = 25'd1 << 10,
		ST_LDIV = 25'd1 << 11,
		ST_DOT  = 25'd1 << 12,
		ST_DRND = 25'd1 << 13,
		ST_RZM  = 25'd1 << 14,
		ST_RZ   = 25'd1 << 15,
		ST_PCHK = 25'd1 << 16,
		ST_PMUL = 25'd1 << 17,
		ST_PSQ  = 25'd1 << 18,
		ST_KD   = 25'd1 << 19,
		ST_DIF  = 25'd1 << 20,
		ST_KS   = 25'd1 << 21,
		ST_SPC  = 25'd1 << 22,
		ST_ACC  = 25'd1 << 23,
		ST_FIN  = 25'd1 << 24
	} state_t;

	function automatic logic signed [ACC_W-1:0] rnd15(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] q;
		mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		q   = (mag + ACC_W'(16384)) >> 15;
		return v[ACC_W-1] ? -signed'(q) : signed'(q);
	endfunction

	// registers
	state_t                       state_q;
	logic [1:0]                   ch_q;
	logic                         go_q;
	logic [9:0]                   radius_q;
	logic [CFG_DATA_W-1:0]        ka_q, kd_q, ks_q;
	logic [7:0]                   shin_q;
	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic signed [15:0]           pos_q [3];
	logic [15:0]                  rgb_q [3];
	logic                         dir_q, last_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic [Z_W-1:0]               z_q;
	logic signed [NL_W-1:0]       n_q [3];
	logic signed [NL_W-1:0]       l_q [3];
	logic signed [V_W-1:0]        v_q [3];
	logic [IU_RES_W-1:0]          len_q;
	logic signed [DOT_W-1:0]      dot_q;
	logic [15:0]                  base_q, power_q;
	logic [7:0]                   e_q;
	logic [31:0]                  prod_q;
	logic [TERM_W-1:0]            term_q [3];
	logic [SUM_W-1:0]             sum_q [3];
	logic                         outside_q;
	logic                         out_valid_q;
	logic [15:0]                  out_rgb_q [3];
	logic                         out_outside_q;

	// combinational
	logic signed [MUL_A_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]     mul_p;
	logic [PROD_W-1:0]            mulq_p;
	logic [15:0]                  ka_c, kd_c, ks_c, coef_c;
	logic [COORD_BITS-1:0]        x_mag, y_mag;
	logic signed [V_W-1:0]        v_sel, pt_sel, rp_v;
	logic [V_W-1:0]               v_mag;
	logic [DIV_N_W-1:0]           div_num;
	logic                         div_neg;
	logic signed [NL_W-1:0]       q_s, div_val;
	iu_req_t                      iu_req;
	iu_rsp_t                      iu_rsp;
	logic signed [ACC_W-1:0]      dot_rnd, rz_full;
	logic [15:0]                  rz_clamp;
	logic [SUM_W:0]               sum_new [3];
	logic                         iter_state, out_free, last_ch;
	logic                         outside_c;

	assign pixel_in.ready = (state_q == ST_IDLE);
	assign cfg.ready      = 1'b1;

	assign shade_out.valid          = out_valid_q;
	assign shade_out.red            = out_rgb_q[0];
	assign shade_out.green          = out_rgb_q[1];
	assign shade_out.blue           = out_rgb_q[2];
	assign shade_out.outside_sphere = out_outside_q;

	// per channel selections
	assign ka_c    = ka_q[16*ch_q +: 16];
	assign kd_c    = kd_q[16*ch_q +: 16];
	assign ks_c    = ks_q[16*ch_q +: 16];
	assign x_mag   = x_q[COORD_BITS-1] ? COORD_BITS'(-x_q) : COORD_BITS'(x_q);
	assign y_mag   = y_q[COORD_BITS-1] ? COORD_BITS'(-y_q) : COORD_BITS'(y_q);
	assign v_sel   = v_q[ch_q];
	assign v_mag   = v_sel[V_W-1] ? V_W'(-v_sel) : V_W'(v_sel);
	assign last_ch = (ch_q == 2'd2);

	// inside test on r*r - x*x - y*y
	assign outside_c = (radius_q == '0) || (acc_q < 0);

	always_comb begin
		unique case (ch_q)
			2'd0:    pt_sel = V_W'(x_q) <<< 12;
			2'd1:    pt_sel = V_W'(y_q) <<< 12;
			default: pt_sel = V_W'(signed'({1'b0, z_q}));
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_AMB:  coef_c = ka_c;
			ST_KD:   coef_c = kd_c;
			default: coef_c = ks_c;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			ST_RR, ST_VMUL: mul_a = MUL_A_W'(signed'({1'b0, radius_q}));
			ST_XX:          mul_a = MUL_A_W'(x_q);
			ST_YY:          mul_a = MUL_A_W'(y_q);
			ST_LMUL:        mul_a = MUL_A_W'(v_sel);
			ST_AMB, ST_KD, ST_KS: mul_a = MUL_A_W'(signed'({1'b0, coef_c}));
			ST_DOT:         mul_a = MUL_A_W'(n_q[ch_q]);
			ST_RZM:         mul_a = MUL_A_W'(dot_q);
			ST_PMUL:        mul_a = MUL_A_W'(signed'({1'b0, power_q}));
			ST_PSQ:         mul_a = MUL_A_W'(signed'({1'b0, base_q}));
			ST_DIF, ST_SPC: mul_a = MUL_A_W'(signed'({1'b0, prod_q}));
			default:        mul_a = '0;
		endcase
		unique case (state_q)
			ST_RR:          mul_b = MUL_B_W'(signed'({1'b0, radius_q}));
			ST_XX:          mul_b = MUL_B_W'(x_q);
			ST_YY:          mul_b = MUL_B_W'(y_q);
			ST_VMUL:        mul_b = MUL_B_W'(pos_q[ch_q]);
			ST_LMUL:        mul_b = MUL_B_W'(v_sel);
			ST_AMB, ST_KD, ST_KS: mul_b = MUL_B_W'(signed'({1'b0, rgb_q[ch_q]}));
			ST_DOT:         mul_b = MUL_B_W'(l_q[ch_q]);
			ST_RZM:         mul_b = MUL_B_W'(n_q[2]);
			ST_PMUL, ST_PSQ: mul_b = MUL_B_W'(signed'({1'b0, base_q}));
			ST_DIF:         mul_b = MUL_B_W'(dot_q);
			ST_SPC:         mul_b = MUL_B_W'(signed'({1'b0, power_q}));
			default:        mul_b = '0;
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign mulq_p = PROD_W'(mul_p) + PROD_W'(16384);
	assign rp_v   = V_W'(mul_p);

	// square root and divide requests
	always_comb begin
		unique case (state_q)
			ST_LDIV: begin
				div_num = (DIV_N_W'(v_mag) << 15) + DIV_N_W'(len_q >> 1);
				div_neg = v_sel[V_W-1];
			end
			default: begin
				unique case (ch_q)
					2'd0:    div_num = (DIV_N_W'(x_mag) << 15) + DIV_N_W'(radius_q[9:1]);
					2'd1:    div_num = (DIV_N_W'(y_mag) << 15) + DIV_N_W'(radius_q[9:1]);
					default: div_num = (DIV_N_W'(z_q) << 3) + DIV_N_W'(radius_q[9:1]);
				endcase
				div_neg = (ch_q == 2'd0) ? x_q[COORD_BITS-1] :
					(ch_q == 2'd1) ? y_q[COORD_BITS-1] : 1'b0;
			end
		endcase
	end

	assign iter_state   = (state_q == ST_SQZ) || (state_q == ST_SQL) ||
		(state_q == ST_NDIV) || (state_q == ST_LDIV);
	assign iu_req.start = iter_state && !go_q;
	assign iu_req.op    = ((state_q == ST_SQZ) || (state_q == ST_SQL)) ? IU_SQRT : IU_DIV;
	assign iu_req.num   = (state_q == ST_SQZ) ? {acc_q[31:0], 24'd0} :
		(state_q == ST_SQL) ? IU_N_W'(acc_q[IU_N_W-1:0]) : IU_N_W'(div_num);
	assign iu_req.den   = (state_q == ST_LDIV) ? len_q : IU_D_W'(radius_q);

	assign q_s     = signed'({1'b0, iu_rsp.result[NL_W-2:0]});
	assign div_val = div_neg ? -q_s : q_s;

	pss_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iu_req),
		.rsp    (iu_rsp)
	);

	// dot product rounding and reflected z
	assign dot_rnd = rnd15(acc_q);
	assign rz_full = rnd15(acc_q <<< 1) - ACC_W'(l_q[2]);
	assign rz_clamp = (rz_full < 0) ? 16'd0 :
		(rz_full > ACC_W'(ONE_Q15)) ? ONE_Q15 : rz_full[15:0];

	// saturating sums
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_new[c] = {1'b0, sum_q[c]} + (SUM_W+1)'(term_q[c]);
		end
	end

	assign out_free = !out_valid_q || shade_out.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 10'd100;
			ka_q     <= '0;
			kd_q     <= '0;
			ks_q     <= '0;
			shin_q   <= 8'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_RADIUS:    radius_q <= cfg.data[9:0];
				CFG_AMBIENT:   ka_q     <= cfg.data;
				CFG_DIFFUSE:   kd_q     <= cfg.data;
				CFG_SPECULAR:  ks_q     <= cfg.data;
				CFG_SHININESS: shin_q   <= cfg.data[7:0];
				default:       ;
			endcase
		end
	end

	// sequencer, sums and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ch_q          <= '0;
			go_q          <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			if (state_q == ST_FIN && last_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (shade_out.valid && shade_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pixel_in.valid) begin
						state_q <= ST_RR;
					end
				end
				ST_RR: state_q <= ST_XX;
				ST_XX: state_q <= ST_YY;
				ST_YY: state_q <= ST_CHK;
				ST_CHK: begin
					state_q <= outside_c ? ST_FIN : ST_SQZ;
					ch_q    <= '0;
				end
				ST_SQZ, ST_SQL, ST_NDIV, ST_LDIV: begin
					if (iu_req.start) begin
						go_q <= 1'b1;
					end else if (iu_rsp.done) begin
						go_q <= 1'b0;
						if (state_q == ST_SQZ) begin
							state_q <= ST_NDIV;
						end else if (state_q == ST_SQL) begin
							state_q <= (iu_rsp.result == '0) ? ST_ACC : ST_LDIV;
						end else begin
							ch_q <= last_ch ? 2'd0 : ch_q + 2'd1;
							if (last_ch) begin
								state_q <= (state_q == ST_NDIV) ? ST_VMUL : ST_DOT;
							end
						end
					end
				end
				ST_VMUL, ST_LMUL, ST_AMB, ST_DOT: begin
					ch_q <= last_ch ? 2'd0 : ch_q + 2'd1;
					if (last_ch) begin
						unique case (state_q)
							ST_VMUL: state_q <= ST_LMUL;
							ST_LMUL: state_q <= ST_AMB;
							ST_AMB:  state_q <= ST_SQL;
							default: state_q <= ST_DRND;
						endcase
					end
				end
				ST_DRND: state_q <= ST_RZM;
				ST_RZM:  state_q <= ST_RZ;
				ST_RZ:   state_q <= ST_PCHK;
				ST_PCHK: begin
					priority if (e_q == '0) begin
						state_q <= ST_KD;
						ch_q    <= '0;
					end else if (e_q[0]) begin
						state_q <= ST_PMUL;
					end else begin
						state_q <= ST_PSQ;
					end
				end
				ST_PMUL: state_q <= ST_PSQ;
				ST_PSQ:  state_q <= ST_PCHK;
				ST_KD:   state_q <= ST_DIF;
				ST_DIF:  state_q <= ST_KS;
				ST_KS:   state_q <= ST_SPC;
				ST_SPC: begin
					ch_q    <= last_ch ? 2'd0 : ch_q + 2'd1;
					state_q <= last_ch ? ST_ACC : ST_KD;
				end
				ST_ACC: begin
					for (int c = 0; c < 3; c++) begin
						sum_q[c] <= sum_new[c][SUM_W] ? {SUM_W{1'b1}} : sum_new[c][SUM_W-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						for (int c = 0; c < 3; c++) begin
							sum_q[c] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q      <= pixel_in.pixel_x;
				y_q      <= pixel_in.pixel_y;
				pos_q[0] <= pixel_in.light_pos_x;
				pos_q[1] <= pixel_in.light_pos_y;
				pos_q[2] <= pixel_in.light_pos_z;
				rgb_q[0] <= pixel_in.light_red;
				rgb_q[1] <= pixel_in.light_green;
				rgb_q[2] <= pixel_in.light_blue;
				dir_q    <= pixel_in.light_is_directional;
				last_q   <= pixel_in.last_light;
			end
			ST_RR: acc_q <= ACC_W'(mul_p);
			ST_XX, ST_YY: acc_q <= acc_q - ACC_W'(mul_p);
			ST_CHK: outside_q <= outside_c;
			ST_SQZ: begin
				if (iu_rsp.done) begin
					z_q <= iu_rsp.result[Z_W-1:0];
				end
			end
			ST_NDIV: begin
				if (iu_rsp.done) begin
					n_q[ch_q] <= div_val;
				end
			end
			ST_VMUL: v_q[ch_q] <= dir_q ? -rp_v : rp_v - pt_sel;
			ST_LMUL, ST_DOT: acc_q <= ((ch_q == 2'd0) ? ACC_W'(0) : acc_q) + ACC_W'(mul_p);
			ST_AMB: term_q[ch_q] <= mul_p[18 +: TERM_W];
			ST_SQL: begin
				if (iu_rsp.done) begin
					len_q <= iu_rsp.result;
				end
			end
			ST_LDIV: begin
				if (iu_rsp.done) begin
					l_q[ch_q] <= div_val;
				end
			end
			ST_DRND: dot_q <= dot_rnd[DOT_W-1:0];
			ST_RZM: acc_q <= ACC_W'(mul_p);
			ST_RZ: begin
				base_q  <= rz_clamp;
				power_q <= ONE_Q15;
				e_q     <= (int'(shin_q) > SHININESS_MAX) ? 8'(SHININESS_MAX) : shin_q;
			end
			ST_PMUL: power_q <= mulq_p[30:15];
			ST_PSQ: begin
				base_q <= mulq_p[30:15];
				e_q    <= e_q >> 1;
			end
			ST_KD, ST_KS: prod_q <= mul_p[31:0];
			ST_DIF: begin
				if (dot_q > 0) begin
					term_q[ch_q] <= term_q[ch_q] + mul_p[33 +: TERM_W];
				end
			end
			ST_SPC: term_q[ch_q] <= term_q[ch_q] + mul_p[33 +: TERM_W];
			ST_FIN: begin
				if (last_q && out_free) begin
					out_outside_q <= outside_q;
					for (int c = 0; c < 3; c++) begin
						out_rgb_q[c] <= outside_q ? 16'd0 :
							(sum_q[c] > SUM_W'(16'hFFFF)) ? 16'hFFFF : sum_q[c][15:0];
					end
				end
			end
			default: ;
		endcase
	end

endmodule

/* dv/phong_sphere_pixel_shader_tb.sv */
`timescale 1ns / 1ps

module phong_sphere_pixel_shader_tb;
	import pss_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic signed [10:0] px;
		logic signed [10:0] py;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] lz;
		logic [15:0]        lr;
		logic [15:0]        lg;
		logic [15:0]        lb;
		logic               dirl;
		logic               last;
	} light_t;

	typedef struct {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic        outside;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint unsigned cycle = 0;
	int errors = 0;
	int long_hold = 0;

	light_t light_q[$];
	shade_t shade_q[$];

	// shader state mirror
	longint unsigned m_radius, m_ka, m_kd, m_ks, m_shin;
	longint unsigned m_sum[3];

	pss_in_if #(.COORD_BITS(11)) pixel_in ();
	pss_out_if shade_out ();
	pss_cfg_if cfg ();

	phong_sphere_pixel_shader u_dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_in(pixel_in), .shade_out(shade_out), .cfg(cfg)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 64'd2000000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint unsigned mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned q15_mul(longint unsigned a, longint unsigned b);
		return (a * b + 16384) >> 15;
	endfunction

	function automatic longint unsigned chan(longint unsigned packed_k, int c);
		return (packed_k >> (16 * c)) & 16'hffff;
	endfunction

	// accumulate one light, push a shade on the last one
	task automatic shade_light(light_t it);
		longint x, y, r, d, z, len, dotp, rz, e;
		longint pt[3], n[3], v[3], l[3], pos[3];
		longint unsigned rgb[3], len2, base, power, term;
		bit outside;
		shade_t s;
		x = it.px;
		y = it.py;
		pos[0] = it.lx; pos[1] = it.ly; pos[2] = it.lz;
		rgb[0] = it.lr; rgb[1] = it.lg; rgb[2] = it.lb;
		r = m_radius;
		d = r * r - x * x - y * y;
		outside = (r == 0) || (d < 0);
		if (!outside) begin
			z = isqrt(d * 64'd16777216);
			pt[0] = x * 4096; pt[1] = y * 4096; pt[2] = z;
			n[0] = round_div(x * 32768, r);
			n[1] = round_div(y * 32768, r);
			n[2] = round_div(z * 8, r);
			len2 = 0;
			for (int c = 0; c < 3; c++) begin
				v[c] = it.dirl ? -(r * pos[c]) : r * pos[c] - pt[c];
				len2 += v[c] * v[c];
			end
			len = isqrt(len2);
			dotp = 0;
			power = 32768;
			if (len > 0) begin
				for (int c = 0; c < 3; c++) l[c] = round_div(v[c] * 32768, len);
				dotp = round_div(n[0] * l[0] + n[1] * l[1] + n[2] * l[2], 32768);
				rz = -l[2] + round_div(2 * dotp * n[2], 32768);
				if (rz < 0) rz = 0;
				if (rz > 32768) rz = 32768;
				base = rz;
				e = (m_shin > 255) ? 255 : m_shin;
				while (e != 0) begin
					if (e & 1) power = q15_mul(power, base);
					base = q15_mul(base, base);
					e >>= 1;
				end
			end
			for (int c = 0; c < 3; c++) begin
				term = (chan(m_ka, c) * rgb[c]) >> 18;
				if (len > 0) begin
					if (dotp > 0) term += (chan(m_kd, c) * rgb[c] * dotp) >> 33;
					term += (chan(m_ks, c) * rgb[c] * power) >> 33;
				end
				m_sum[c] = (m_sum[c] + term > 24'hffffff) ? 24'hffffff : m_sum[c] + term;
			end
		end
		if (it.last) begin
			s.outside = outside;
			s.r = outside ? 16'd0 : (m_sum[0] > 16'hffff ? 16'hffff : m_sum[0][15:0]);
			s.g = outside ? 16'd0 : (m_sum[1] > 16'hffff ? 16'hffff : m_sum[1][15:0]);
			s.b = outside ? 16'd0 : (m_sum[2] > 16'hffff ? 16'hffff : m_sum[2][15:0]);
			shade_q.push_back(s);
			m_sum = '{0, 0, 0};
		end
	endtask

	// driver: offers queued lights with random gaps
	int drv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_in.valid <= 1'b0;
			pixel_in.pixel_x <= '0;
			pixel_in.pixel_y <= '0;
			pixel_in.light_pos_x <= '0;
			pixel_in.light_pos_y <= '0;
			pixel_in.light_pos_z <= '0;
			pixel_in.light_red <= '0;
			pixel_in.light_green <= '0;
			pixel_in.light_blue <= '0;
			pixel_in.light_is_directional <= 1'b0;
			pixel_in.last_light <= 1'b0;
			drv_gap = 0;
		end else begin
			if (pixel_in.valid && pixel_in.ready) begin
				shade_light(light_q.pop_front());
				drv_gap = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0) drv_gap = 0;
			end
			if (!pixel_in.valid || pixel_in.ready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					pixel_in.valid <= 1'b0;
				end else if (light_q.size() > 0) begin
					pixel_in.valid <= 1'b1;
					pixel_in.pixel_x <= light_q[0].px;
					pixel_in.pixel_y <= light_q[0].py;
					pixel_in.light_pos_x <= light_q[0].lx;
					pixel_in.light_pos_y <= light_q[0].ly;
					pixel_in.light_pos_z <= light_q[0].lz;
					pixel_in.light_red <= light_q[0].lr;
					pixel_in.light_green <= light_q[0].lg;
					pixel_in.light_blue <= light_q[0].lb;
					pixel_in.light_is_directional <= light_q[0].dirl;
					pixel_in.last_light <= light_q[0].last;
				end else begin
					pixel_in.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each shade beat, stalls at random
	int mon_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade_out.ready <= 1'b0;
			mon_gap = 0;
		end else begin
			if (shade_out.valid && shade_out.ready) begin
				if (shade_q.size() == 0) begin
					$display("%0t: shade beat with nothing expected", $time);
					errors++;
				end else begin
					shade_t s;
					s = shade_q.pop_front();
					if (shade_out.red !== s.r || shade_out.green !== s.g ||
					    shade_out.blue !== s.b || shade_out.outside_sphere !== s.outside) begin
						$display("%0t: shade mismatch exp %h %h %h %b got %h %h %h %b",
							$time, s.r, s.g, s.b, s.outside, shade_out.red,
							shade_out.green, shade_out.blue, shade_out.outside_sphere);
						errors++;
					end
				end
				mon_gap = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0) mon_gap = 0;
			end
			if (long_hold > 0) begin
				long_hold--;
				shade_out.ready <= 1'b0;
			end else if (mon_gap > 0) begin
				mon_gap--;
				shade_out.ready <= 1'b0;
			end else begin
				shade_out.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_RADIUS:    m_radius = val & 10'h3ff;
			CFG_AMBIENT:   m_ka = val & 48'hffffffffffff;
			CFG_DIFFUSE:   m_kd = val & 48'hffffffffffff;
			CFG_SPECULAR:  m_ks = val & 48'hffffffffffff;
			CFG_SHININESS: m_shin = val & 8'hff;
			default: ;
		endcase
	endtask

	// wait for every shade, then cover the tail of a light with no result
	task automatic drain();
		while (light_q.size() > 0 || pixel_in.valid || shade_q.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic light_t rand_light(int rad, bit last);
		light_t it;
		int span;
		span = (rad > 0 && rad < 1023) ? rad + 2 : 1023;
		if ($urandom_range(0, 9) == 0) begin
			it.px = 11'($urandom); it.py = 11'($urandom);
			if (it.px == -1024) it.px = -1023;
			if (it.py == -1024) it.py = -1023;
		end else begin
			it.px = 11'($urandom_range(0, 2 * span) - span);
			it.py = 11'($urandom_range(0, 2 * span) - span);
		end
		it.lx = 16'($urandom); it.ly = 16'($urandom); it.lz = 16'($urandom);
		if ($urandom_range(0, 1)) it.lz = 16'($urandom_range(4096, 32767));
		it.lr = 16'($urandom); it.lg = 16'($urandom); it.lb = 16'($urandom);
		it.dirl = 1'($urandom);
		it.last = last;
		return it;
	endfunction

	task automatic push_pixel(int rad);
		light_t it;
		int n;
		n = $urandom_range(1, 4);
		it = rand_light(rad, 1'b0);
		for (int k = 0; k < n; k++) begin
			light_t li;
			li = rand_light(rad, k == n - 1);
			if ($urandom_range(0, 7) != 0) begin
				li.px = it.px; li.py = it.py;
			end
			light_q.push_back(li);
		end
	endtask

	function automatic longint unsigned rand48();
		return {$urandom, $urandom} & 48'hffffffffffff;
	endfunction

	initial begin
		int radii[6];
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		m_radius = 100; m_ka = 0; m_kd = 0; m_ks = 0; m_shin = 1;
		m_sum = '{0, 0, 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// defaults first: ambient off, so only zero shades
		light_q.push_back('{0, 0, 0, 0, 16'sd8192, 16'hffff, 16'hffff, 16'hffff, 0, 1});
		drain();

		write_reg(CFG_AMBIENT, 48'h8000_8000_8000);
		write_reg(CFG_DIFFUSE, 48'hffff_ffff_ffff);
		write_reg(CFG_SPECULAR, 48'hffff_ffff_ffff);
		write_reg(CFG_SHININESS, 8);
		write_reg(CFG_UNUSED, 48'h1234);

		// directed: centre, rim, outside, extremes, zero-length vector, mixed pixels
		light_q.push_back('{0, 0, 0, 0, 16'sd8192, 16'hffff, 16'hffff, 16'hffff, 1, 1});
		light_q.push_back('{0, 0, 0, 0, 16'sd8192, 16'hffff, 16'hffff, 16'hffff, 0, 1});
		light_q.push_back('{100, 0, 0, 0, 16'sd4096, 16'h8000, 16'h4000, 16'h0001, 0, 1});
		light_q.push_back('{101, 0, 0, 0, 16'sd4096, 16'hffff, 16'hffff, 16'hffff, 0, 1});
		light_q.push_back('{-1023, -1023, -32768, -32768, -32768, 0, 0, 0, 1, 1});
		light_q.push_back('{1023, 1023, 32767, 32767, 32767, 16'hffff, 0, 0, 0, 1});
		light_q.push_back('{0, 0, 0, 0, 0, 16'hffff, 16'h1234, 16'h8000, 1, 1});
		light_q.push_back('{0, 0, 0, 0, 16'sd4096, 16'hffff, 16'hffff, 16'hffff, 0, 1});
		light_q.push_back('{-60, 80, 0, 0, 16'sd8192, 16'hffff, 16'hffff, 16'hffff, 0, 0});
		light_q.push_back('{30, -40, 16'sd4096, 16'sd4096, 16'sd4096, 16'hffff, 16'h5555,
			16'haaaa, 0, 0});
		light_q.push_back('{200, 0, 0, 0, 16'sd8192, 16'hffff, 16'hffff, 16'hffff, 0, 0});
		light_q.push_back('{30, -40, 16'sd4096, 16'sd4096, 16'sd4096, 16'hffff, 16'h5555,
			16'haaaa, 1, 1});
		light_q.push_back('{10, 10, 0, 0, 16'sd8192, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0});
		light_q.push_back('{300, 300, 0, 0, 16'sd8192, 16'h7fff, 16'h7fff, 16'h7fff, 0, 1});
		for (int k = 0; k < 6; k++)
			light_q.push_back('{-5, 7, 16'sd8192, 0, 16'sd16384, 16'hffff, 16'hffff,
				16'hffff, 0, k == 5});
		drain();

		write_reg(CFG_SHININESS, 0);
		light_q.push_back('{0, 0, 0, 0, 16'sd8192, 16'hffff, 16'hffff, 16'hffff, 0, 1});
		drain();
		write_reg(CFG_SHININESS, 255);
		light_q.push_back('{0, 0, 0, 0, 16'sd8192, 16'hffff, 16'hffff, 16'hffff, 0, 1});
		drain();

		// random phases over several register settings
		radii = '{1, 1023, 100, 17, 600, 50};
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_RADIUS, radii[ph]);
			write_reg(CFG_AMBIENT, ph == 1 ? 48'hffff_ffff_ffff : rand48());
			write_reg(CFG_DIFFUSE, ph == 2 ? 48'h0 : rand48());
			write_reg(CFG_SPECULAR, rand48());
			write_reg(CFG_SHININESS, ph == 3 ? 255 : $urandom_range(0, 40));
			while (light_q.size() < 320) push_pixel(radii[ph]);
			if (ph == 2) begin
				// output held off while lights keep coming
				@(posedge clk);
				long_hold = 3000;
			end
			drain();
		end

		if (errors == 0 && shade_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* phong_sphere_pixel_shader.f */
src/pss_pkg.sv
src/pss_if.sv
src/pss_iter_unit.sv
src/phong_sphere_pixel_shader.sv
dv/phong_sphere_pixel_shader_tb.sv
